/* hdl/alle_pkg.sv */
// Shared types and codes for the array linked list engine.
// No dependencies.
package alle_pkg;

    localparam int SLOT_W = 8;
    localparam int WORD_W = 32;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_INS_AFTER  = 2'd0;
    localparam cmd_t CMD_INS_BEFORE = 2'd1;
    localparam cmd_t CMD_DELETE     = 2'd2;
    localparam cmd_t CMD_READ       = 2'd3;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_ANCHOR = 2'd1;
    localparam status_t ST_FULL       = 2'd2;
    localparam status_t ST_BAD_DELETE = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   result_slot;
        logic [WORD_W-1:0]   slot_value;
        logic [SLOT_W-1:0]   next_slot;
        logic [SLOT_W-1:0]   prev_slot;
        logic                slot_used;
    } rsp_t;

endpackage

/* hdl/alle_if.sv */
// Command and response channel interfaces (valid/ready).
// Depends on alle_pkg.
interface alle_cmd_if;
    logic                          valid;
    logic                          ready;
    alle_pkg::cmd_t                command;
    logic [alle_pkg::SLOT_W-1:0]   slot;
    logic [alle_pkg::WORD_W-1:0]   value;

    modport source (output valid, output command, output slot, output value, input ready);
    modport sink   (input valid, input command, input slot, input value, output ready);
endinterface

interface alle_rsp_if;
    logic                          valid;
    logic                          ready;
    alle_pkg::status_t             status;
    logic [alle_pkg::SLOT_W-1:0]   result_slot;
    logic [alle_pkg::WORD_W-1:0]   slot_value;
    logic [alle_pkg::SLOT_W-1:0]   next_slot;
    logic [alle_pkg::SLOT_W-1:0]   prev_slot;
    logic                          slot_used;

    modport source (output valid, output status, output result_slot, output slot_value,
                    output next_slot, output prev_slot, output slot_used, input ready);
    modport sink   (input valid, input status, input result_slot, input slot_value,
                    input next_slot, input prev_slot, input slot_used, output ready);
endinterface

/* hdl/array_linked_list_engine.sv */
// Doubly linked list engine over slot memories with a free chain; top level.
// A read checks the slot and reports it. An insert reads the anchor row and its successor,
// then writes the new slot, the successor and the anchor (one row in an empty list); a delete
// frees the slot, then writes its predecessor and successor (one row for the last element);
// a rejected command skips the writes. Commands are taken one at a time, set by the single
// write port of the link memory. Reset: asynchronous, active low; a clearing pass then writes
// every link entry, with no command taken until it ends. Data words are never cleared.
module array_linked_list_engine #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    alle_cmd_if.sink    cmd,
    alle_rsp_if.source  rsp
);

    localparam int SW = $clog2(CAPACITY);
    localparam int RW = 2 * SW + 1;

    logic                    link_we;
    logic [SW-1:0]           link_waddr;
    logic [RW-1:0]           link_wdata;
    logic [SW-1:0]           link_raddr_a;
    logic [SW-1:0]           link_raddr_b;
    logic [RW-1:0]           link_rdata_a;
    logic [RW-1:0]           link_rdata_b;
    logic                    val_we;
    logic [SW-1:0]           val_waddr;
    logic [VALUE_WIDTH-1:0]  val_wdata;
    logic [SW-1:0]           val_raddr;
    logic [VALUE_WIDTH-1:0]  val_rdata;

    alle_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .link_we      (link_we),
        .link_waddr   (link_waddr),
        .link_wdata   (link_wdata),
        .link_raddr_a (link_raddr_a),
        .link_raddr_b (link_raddr_b),
        .link_rdata_a (link_rdata_a),
        .link_rdata_b (link_rdata_b),
        .val_we       (val_we),
        .val_waddr    (val_waddr),
        .val_wdata    (val_wdata),
        .val_raddr    (val_raddr),
        .val_rdata    (val_rdata)
    );

    alle_link_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (RW)
    ) u_link_ram (
        .clk     (clk),
        .we      (link_we),
        .waddr   (link_waddr),
        .wdata   (link_wdata),
        .raddr_a (link_raddr_a),
        .raddr_b (link_raddr_b),
        .rdata_a (link_rdata_a),
        .rdata_b (link_rdata_b)
    );

    alle_value_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

endmodule

/* hdl/alle_link_ram.sv */
// Link memory: {used, prev, next} per slot, one write port, two registered read ports.
// No dependencies.
module alle_link_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/alle_value_ram.sv */
// Data word memory, one write port and one registered read port.
// No dependencies.
module alle_value_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/alle_ctrl.sv */
// Command sequencer: link clearing pass, free chain, read-modify-write of links, result register.
// Depends on alle_pkg and alle_if; drives alle_link_ram and alle_value_ram.
module alle_ctrl #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    alle_cmd_if.sink                      cmd,
    alle_rsp_if.source                    rsp,
    output logic                          link_we,
    output logic [$clog2(CAPACITY)-1:0]   link_waddr,
    output logic [2*$clog2(CAPACITY):0]   link_wdata,
    output logic [$clog2(CAPACITY)-1:0]   link_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]   link_raddr_b,
    input  logic [2*$clog2(CAPACITY):0]   link_rdata_a,
    input  logic [2*$clog2(CAPACITY):0]   link_rdata_b,
    output logic                          val_we,
    output logic [$clog2(CAPACITY)-1:0]   val_waddr,
    output logic [VALUE_WIDTH-1:0]        val_wdata,
    output logic [$clog2(CAPACITY)-1:0]   val_raddr,
    input  logic [VALUE_WIDTH-1:0]        val_rdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int RW = 2 * SW + 1;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHK      = 4'd2;
    localparam logic [3:0] S_INS_ANC  = 4'd3;
    localparam logic [3:0] S_INS_SUCC = 4'd4;
    localparam logic [3:0] S_INS_WS   = 4'd5;
    localparam logic [3:0] S_INS_WA   = 4'd6;
    localparam logic [3:0] S_DEL_RD   = 4'd7;
    localparam logic [3:0] S_DEL_WP   = 4'd8;
    localparam logic [3:0] S_DEL_WN   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    function automatic logic row_used(input logic [RW-1:0] r);
        return r[2*SW];
    endfunction

    function automatic logic [SW-1:0] row_prev(input logic [RW-1:0] r);
        return r[2*SW-1:SW];
    endfunction

    function automatic logic [SW-1:0] row_next(input logic [RW-1:0] r);
        return r[SW-1:0];
    endfunction

    function automatic logic [RW-1:0] mk_row(input logic u, input logic [SW-1:0] p,
                                             input logic [SW-1:0] n);
        return {u, p, n};
    endfunction

    function automatic logic [alle_pkg::WORD_W-1:0] out_word(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[alle_pkg::WORD_W-1:0];
    endfunction

    // Fields of an addressed slot; zero when the slot lies beyond the array.
    function automatic alle_pkg::rsp_t report(input alle_pkg::status_t st,
                                              input logic [alle_pkg::SLOT_W-1:0] s,
                                              input logic in_range,
                                              input logic [RW-1:0] r,
                                              input logic [VALUE_WIDTH-1:0] v);
        alle_pkg::rsp_t o;
        o = '0;
        o.status      = st;
        o.result_slot = s;
        if (in_range)
        begin
            o.slot_value = (row_used(r) && s != '0) ? out_word(v) : '0;
            o.next_slot  = alle_pkg::SLOT_W'(row_next(r));
            o.prev_slot  = alle_pkg::SLOT_W'(row_prev(r));
            o.slot_used  = row_used(r);
        end
        return o;
    endfunction

    logic [3:0]                     state_reg, state_next;
    logic [SW-1:0]                  init_cnt_reg, init_cnt_next;
    logic [SW-1:0]                  free_head_reg, free_head_next;
    logic [SW-1:0]                  free_count_reg, free_count_next;
    logic                           out_valid_reg, out_valid_next;

    alle_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [alle_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [VALUE_WIDTH-1:0]         value_reg, value_next;
    logic [RW-1:0]                  row_s_reg, row_s_next;
    logic [VALUE_WIDTH-1:0]         vals_reg, vals_next;
    logic [SW-1:0]                  fnext_reg, fnext_next;
    logic [SW-1:0]                  anchor_reg, anchor_next;
    logic [SW-1:0]                  fresh_reg, fresh_next;
    logic [RW-1:0]                  row_a_reg, row_a_next;
    logic [RW-1:0]                  row_b_reg, row_b_next;
    alle_pkg::rsp_t                 res_reg, res_next;
    alle_pkg::rsp_t                 out_reg, out_next;

    logic [SW-1:0]                  s_idx;
    logic                           s_ok;
    logic                           s_in;
    logic                           list_full;
    logic                           cmd_acc;

    assign s_idx     = SW'(slot_reg);
    assign s_ok      = 32'(slot_reg) < CAPACITY;
    assign s_in      = s_ok && row_used(link_rdata_a);
    assign list_full = (free_count_reg == '0) || (32'(free_head_reg) >= CAPACITY);
    assign cmd_acc   = cmd.valid && cmd.ready;

    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.result_slot = out_reg.result_slot;
    assign rsp.slot_value  = out_reg.slot_value;
    assign rsp.next_slot   = out_reg.next_slot;
    assign rsp.prev_slot   = out_reg.prev_slot;
    assign rsp.slot_used   = out_reg.slot_used;

    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        row_s_next      = row_s_reg;
        vals_next       = vals_reg;
        fnext_next      = fnext_reg;
        anchor_next     = anchor_reg;
        fresh_next      = fresh_reg;
        row_a_next      = row_a_reg;
        row_b_next      = row_b_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        link_we      = 1'b0;
        link_waddr   = '0;
        link_wdata   = '0;
        link_raddr_a = s_idx;
        link_raddr_b = free_head_reg;
        val_we       = 1'b0;
        val_waddr    = free_head_reg;
        val_wdata    = value_reg;
        val_raddr    = s_idx;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                link_we    = 1'b1;
                link_waddr = init_cnt_reg;
                link_wdata = mk_row(init_cnt_reg == '0, '0,
                                    (init_cnt_reg == '0 || init_cnt_reg == SW'(CAPACITY - 1))
                                    ? '0 : SW'(init_cnt_reg + 1'b1));
                init_cnt_next = SW'(init_cnt_reg + 1'b1);
                if (init_cnt_reg == SW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                link_raddr_a = SW'(cmd.slot);
                val_raddr    = SW'(cmd.slot);
                if (cmd.valid)
                begin
                    cmd_next   = cmd.command;
                    slot_next  = cmd.slot;
                    value_next = VALUE_WIDTH'(cmd.value);
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                row_s_next = link_rdata_a;
                vals_next  = val_rdata;
                fnext_next = row_next(link_rdata_b);
                unique case (cmd_reg)
                    alle_pkg::CMD_READ:
                    begin
                        res_next   = report(alle_pkg::ST_OK, slot_reg, s_ok,
                                            link_rdata_a, val_rdata);
                        state_next = S_DONE;
                    end
                    alle_pkg::CMD_DELETE:
                    begin
                        if (slot_reg == '0 || !s_in)
                        begin
                            res_next   = report(alle_pkg::ST_BAD_DELETE, slot_reg, s_ok,
                                                link_rdata_a, val_rdata);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            link_raddr_a = row_prev(link_rdata_a);
                            link_raddr_b = row_next(link_rdata_a);
                            state_next   = S_DEL_RD;
                        end
                    end
                    alle_pkg::CMD_INS_BEFORE:
                    begin
                        if (!s_in)
                        begin
                            res_next   = report(alle_pkg::ST_BAD_ANCHOR, slot_reg, s_ok,
                                                link_rdata_a, val_rdata);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            anchor_next  = row_prev(link_rdata_a);
                            link_raddr_a = row_prev(link_rdata_a);
                            state_next   = S_INS_ANC;
                        end
                    end
                    alle_pkg::CMD_INS_AFTER:
                    begin
                        anchor_next = s_idx;
                        row_a_next  = link_rdata_a;
                        if (!s_in)
                        begin
                            res_next   = report(alle_pkg::ST_BAD_ANCHOR, slot_reg, s_ok,
                                                link_rdata_a, val_rdata);
                            state_next = S_DONE;
                        end
                        else if (list_full)
                        begin
                            res_next   = report(alle_pkg::ST_FULL, slot_reg, s_ok,
                                                link_rdata_a, val_rdata);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            link_raddr_a = row_next(link_rdata_a);
                            state_next   = S_INS_SUCC;
                        end
                    end
                endcase
            end

            S_INS_ANC:
            begin
                row_a_next = link_rdata_a;
                if (!(32'(anchor_reg) < CAPACITY && row_used(link_rdata_a)))
                begin
                    res_next   = report(alle_pkg::ST_BAD_ANCHOR, slot_reg, s_ok,
                                        row_s_reg, vals_reg);
                    state_next = S_DONE;
                end
                else if (list_full)
                begin
                    res_next   = report(alle_pkg::ST_FULL, slot_reg, s_ok, row_s_reg, vals_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    link_raddr_a = row_next(link_rdata_a);
                    state_next   = S_INS_SUCC;
                end
            end

            S_INS_SUCC:
            begin
                // new slot is written while the successor row lands
                row_b_next      = link_rdata_a;
                fresh_next      = free_head_reg;
                link_we         = 1'b1;
                link_waddr      = free_head_reg;
                link_wdata      = mk_row(1'b1, anchor_reg, row_next(row_a_reg));
                val_we          = 1'b1;
                free_head_next  = fnext_reg;
                free_count_next = SW'(free_count_reg - 1'b1);
                res_next.status      = alle_pkg::ST_OK;
                res_next.result_slot = alle_pkg::SLOT_W'(free_head_reg);
                res_next.slot_value  = out_word(value_reg);
                res_next.next_slot   = alle_pkg::SLOT_W'(row_next(row_a_reg));
                res_next.prev_slot   = alle_pkg::SLOT_W'(anchor_reg);
                res_next.slot_used   = 1'b1;
                state_next = S_INS_WS;
            end

            S_INS_WS:
            begin
                link_we = 1'b1;
                if (row_next(row_a_reg) == anchor_reg)
                begin
                    // empty ring: anchor is its own successor
                    link_waddr = anchor_reg;
                    link_wdata = mk_row(row_used(row_a_reg), fresh_reg, fresh_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    link_waddr = row_next(row_a_reg);
                    link_wdata = mk_row(row_used(row_b_reg), fresh_reg, row_next(row_b_reg));
                    state_next = S_INS_WA;
                end
            end

            S_INS_WA:
            begin
                link_we    = 1'b1;
                link_waddr = anchor_reg;
                link_wdata = mk_row(row_used(row_a_reg), row_prev(row_a_reg), fresh_reg);
                state_next = S_DONE;
            end

            S_DEL_RD:
            begin
                row_a_next      = link_rdata_a;
                row_b_next      = link_rdata_b;
                link_we         = 1'b1;
                link_waddr      = s_idx;
                link_wdata      = mk_row(1'b0, '0, free_head_reg);
                free_head_next  = s_idx;
                free_count_next = SW'(free_count_reg + 1'b1);
                res_next             = '0;
                res_next.status      = alle_pkg::ST_OK;
                res_next.result_slot = slot_reg;
                res_next.next_slot   = alle_pkg::SLOT_W'(free_head_reg);
                state_next = S_DEL_WP;
            end

            S_DEL_WP:
            begin
                link_we    = 1'b1;
                link_waddr = row_prev(row_s_reg);
                if (row_prev(row_s_reg) == row_next(row_s_reg))
                begin
                    link_wdata = mk_row(row_used(row_a_reg), row_prev(row_s_reg),
                                        row_next(row_s_reg));
                    state_next = S_DONE;
                end
                else
                begin
                    link_wdata = mk_row(row_used(row_a_reg), row_prev(row_a_reg),
                                        row_next(row_s_reg));
                    state_next = S_DEL_WN;
                end
            end

            S_DEL_WN:
            begin
                link_we    = 1'b1;
                link_waddr = row_next(row_s_reg);
                link_wdata = mk_row(row_used(row_b_reg), row_prev(row_s_reg),
                                    row_next(row_b_reg));
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            free_head_reg  <= SW'(1);
            free_count_reg <= SW'(CAPACITY - 1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        row_s_reg  <= row_s_next;
        vals_reg   <= vals_next;
        fnext_reg  <= fnext_next;
        anchor_reg <= anchor_next;
        fresh_reg  <= fresh_next;
        row_a_reg  <= row_a_next;
        row_b_reg  <= row_b_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

`ifndef SYNTH
    a_no_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_CHK || state_reg == S_INS_ANC
         || state_reg == S_DONE) |-> !link_we)
        else $error("link write outside a write step");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> (state_reg == S_CHK))
        else $error("accepted word did not enter check");

    a_insert_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_SUCC) |=>
        (free_count_reg == SW'($past(free_count_reg) - 1'b1)) && (fresh_reg != '0))
        else $error("insert did not take a free slot");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside done");
`endif

endmodule

/* tb/sv/array_linked_list_engine_tb.sv */
// Testbench for array_linked_list_engine: drives commands through the cmd channel, predicts
// each response word from a local copy of the slot arrays and free chain, and checks it.
// Depends on alle_pkg, alle_if.sv and the engine RTL.
`timescale 1ns / 1ps

module array_linked_list_engine_tb;

    localparam int NSLOT = 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    alle_cmd_if cmd_if ();
    alle_rsp_if rsp_if ();

    array_linked_list_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    // local copy of the list
    logic [alle_pkg::WORD_W-1:0] lst_value [NSLOT];
    logic [alle_pkg::SLOT_W-1:0] lst_next  [NSLOT];
    logic [alle_pkg::SLOT_W-1:0] lst_prev  [NSLOT];
    bit                          lst_used  [NSLOT];
    logic [alle_pkg::SLOT_W-1:0] free_top;
    logic [8:0]                  free_len;

    alle_pkg::rsp_t views_owed [$];
    int   errors = 0;
    bit   src_gaps_on = 1'b1;
    bit   sink_gaps_on = 1'b1;
    int   hold_off_len = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("array_linked_list_engine_tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void reset_list();
        for (int i = 0; i < NSLOT; i++)
        begin
            lst_value[i] = '0;
            lst_next[i]  = alle_pkg::SLOT_W'((i + 1) % NSLOT);
            lst_prev[i]  = '0;
            lst_used[i]  = 1'b0;
        end
        lst_next[0] = '0;
        lst_used[0] = 1'b1;
        free_top    = alle_pkg::SLOT_W'(1);
        free_len    = 9'(NSLOT - 1);
    endfunction

    function automatic alle_pkg::rsp_t slot_view(alle_pkg::status_t st,
                                                 logic [alle_pkg::SLOT_W-1:0] s);
        alle_pkg::rsp_t v;
        v.status      = st;
        v.result_slot = s;
        // data word only shown for a linked slot other than the head
        v.slot_value  = (lst_used[s] && s != 0) ? lst_value[s] : '0;
        v.next_slot   = lst_next[s];
        v.prev_slot   = lst_prev[s];
        v.slot_used   = lst_used[s];
        return v;
    endfunction

    function automatic alle_pkg::rsp_t apply_to_list(alle_pkg::cmd_t op,
                                                     logic [alle_pkg::SLOT_W-1:0] s,
                                                     logic [alle_pkg::WORD_W-1:0] word);
        logic [alle_pkg::SLOT_W-1:0] anchor;
        logic [alle_pkg::SLOT_W-1:0] fresh;
        logic [alle_pkg::SLOT_W-1:0] succ;
        logic [alle_pkg::SLOT_W-1:0] p;
        logic [alle_pkg::SLOT_W-1:0] n;
        case (op)
            alle_pkg::CMD_INS_AFTER, alle_pkg::CMD_INS_BEFORE:
            begin
                if (!lst_used[s])
                    return slot_view(alle_pkg::ST_BAD_ANCHOR, s);
                anchor = (op == alle_pkg::CMD_INS_AFTER) ? s : lst_prev[s];
                if (!lst_used[anchor])
                    return slot_view(alle_pkg::ST_BAD_ANCHOR, s);
                if (free_len == 0)
                    return slot_view(alle_pkg::ST_FULL, s);
                fresh = free_top;
                free_top = lst_next[fresh];
                free_len--;
                succ = lst_next[anchor];
                lst_value[fresh] = word;
                lst_prev[fresh]  = anchor;
                lst_next[fresh]  = succ;
                lst_used[fresh]  = 1'b1;
                lst_prev[succ]   = fresh;
                lst_next[anchor] = fresh;
                return slot_view(alle_pkg::ST_OK, fresh);
            end
            alle_pkg::CMD_DELETE:
            begin
                if (s == 0 || !lst_used[s])
                    return slot_view(alle_pkg::ST_BAD_DELETE, s);
                p = lst_prev[s];
                n = lst_next[s];
                lst_next[p] = n;
                lst_prev[n] = p;
                lst_used[s] = 1'b0;
                lst_prev[s] = '0;
                lst_next[s] = free_top;
                free_top = s;
                free_len++;
                return slot_view(alle_pkg::ST_OK, s);
            end
            default:
                return slot_view(alle_pkg::ST_OK, s);
        endcase
    endfunction

    // random linked slot, scanning from a random start; 0 if none qualifies
    function automatic logic [alle_pkg::SLOT_W-1:0] any_used_slot(bit allow_head);
        int start;
        logic [alle_pkg::SLOT_W-1:0] s;
        start = $urandom_range(NSLOT - 1, 0);
        for (int k = 0; k < NSLOT; k++)
        begin
            s = alle_pkg::SLOT_W'(start + k);
            if (lst_used[s] && (allow_head || s != 0))
                return s;
        end
        return '0;
    endfunction

    task automatic send_word(alle_pkg::cmd_t op, logic [alle_pkg::SLOT_W-1:0] s,
                             logic [alle_pkg::WORD_W-1:0] word);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid   = 1'b1;
        cmd_if.command = op;
        cmd_if.slot    = s;
        cmd_if.value   = word;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        views_owed.push_back(apply_to_list(op, s, word));
    endtask

    task automatic wait_settled();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (views_owed.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_insert(logic [alle_pkg::WORD_W-1:0] word);
        alle_pkg::cmd_t op;
        op = $urandom_range(1, 0) ? alle_pkg::CMD_INS_AFTER : alle_pkg::CMD_INS_BEFORE;
        send_word(op, any_used_slot(1'b1), word);
    endtask

    // response side: ready pacing, with an optional long hold-off
    initial
    begin : sink_pacing
        int gap;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0)
            begin
                gap = hold_off_len;
                hold_off_len = 0;
                rsp_if.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                gap = sink_gaps_on ? pick_gap() : 0;
                if (gap > 0)
                begin
                    rsp_if.ready = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                else
                    rsp_if.ready = 1'b1;
            end
        end
    end

    function automatic void compare_field(string field, logic [31:0] want_v,
                                          logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, actual %0h", field, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_views
        alle_pkg::rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (views_owed.size() == 0)
            begin
                $error("response word with nothing outstanding, result_slot %0d",
                       rsp_if.result_slot);
                errors++;
            end
            else
            begin
                want = views_owed.pop_front();
                compare_field("status", 32'(want.status), 32'(rsp_if.status));
                compare_field("result_slot", 32'(want.result_slot),
                              32'(rsp_if.result_slot));
                compare_field("slot_value", 32'(want.slot_value), 32'(rsp_if.slot_value));
                compare_field("next_slot", 32'(want.next_slot), 32'(rsp_if.next_slot));
                compare_field("prev_slot", 32'(want.prev_slot), 32'(rsp_if.prev_slot));
                compare_field("slot_used", 32'(want.slot_used), 32'(rsp_if.slot_used));
            end
        end
    end

    task automatic test_guards_and_edges();
        send_word(alle_pkg::CMD_READ, 8'd0, 32'h0);
        send_word(alle_pkg::CMD_READ, 8'd255, 32'hFFFF_FFFF);
        send_word(alle_pkg::CMD_INS_AFTER, 8'd255, 32'h1234_5678);    // anchor free
        send_word(alle_pkg::CMD_INS_BEFORE, 8'd255, 32'h1234_5678);
        send_word(alle_pkg::CMD_DELETE, 8'd0, 32'h0);                 // head guard
        send_word(alle_pkg::CMD_DELETE, 8'd255, 32'h0);               // free target
        send_word(alle_pkg::CMD_INS_BEFORE, 8'd0, 32'h0000_0000);     // into empty list
        send_word(alle_pkg::CMD_INS_AFTER, 8'd0, 32'hFFFF_FFFF);
        send_word(alle_pkg::CMD_INS_BEFORE, 8'd1, 32'hA5A5_A5A5);
        send_word(alle_pkg::CMD_INS_AFTER, 8'd1, 32'h5A5A_5A5A);      // after the tail
        send_word(alle_pkg::CMD_INS_BEFORE, 8'd0, 32'h8000_0001);     // append
        send_word(alle_pkg::CMD_READ, 8'd3, 32'h0);
        send_word(alle_pkg::CMD_DELETE, 8'd3, 32'h0);
        send_word(alle_pkg::CMD_DELETE, 8'd3, 32'h0);                 // already freed
        send_word(alle_pkg::CMD_READ, 8'd3, 32'h0);
        send_word(alle_pkg::CMD_INS_AFTER, 8'd3, 32'hDEAD_BEEF);      // freed anchor
        send_word(alle_pkg::CMD_INS_AFTER, 8'd2, 32'h0F0F_F0F0);      // reuses freed slot
        send_word(alle_pkg::CMD_DELETE, 8'd5, 32'h0);
        send_word(alle_pkg::CMD_DELETE, 8'd2, 32'h0);
        send_word(alle_pkg::CMD_READ, 8'd128, 32'h0);
        send_word(alle_pkg::CMD_READ, 8'd0, 32'h0);
        wait_settled();
    endtask

    task automatic test_fill_to_capacity();
        while (free_len != 0)
            send_insert({$urandom});
        send_word(alle_pkg::CMD_INS_AFTER, 8'd0, {$urandom});
        send_word(alle_pkg::CMD_INS_BEFORE, any_used_slot(1'b0), {$urandom});
        send_word(alle_pkg::CMD_READ, 8'd255, 32'h0);
        send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), 32'h0);
        send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), 32'h0);
        repeat (3) send_insert({$urandom});
        wait_settled();
    endtask

    task automatic test_drain_to_empty();
        while (free_len != 9'(NSLOT - 1))
        begin
            if ($urandom_range(9, 0) == 0)
                send_word(alle_pkg::CMD_READ, 8'($urandom_range(255, 0)), {$urandom});
            send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), {$urandom});
        end
        send_word(alle_pkg::CMD_DELETE, 8'($urandom_range(255, 1)), 32'h0);
        send_word(alle_pkg::CMD_READ, 8'd0, 32'h0);
        send_word(alle_pkg::CMD_INS_AFTER, 8'd0, {$urandom});
        send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), 32'h0);
        send_word(alle_pkg::CMD_INS_BEFORE, 8'd0, {$urandom});
        wait_settled();
    endtask

    // output held off for a long stretch while words keep coming, no gaps
    task automatic test_output_stall();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        hold_off_len = 400;
        for (int i = 0; i < 40; i++)
        begin
            case ($urandom_range(2, 0))
                0: send_insert({$urandom});
                1: send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), 32'h0);
                default: send_word(alle_pkg::CMD_READ, any_used_slot(1'b1), 32'h0);
            endcase
        end
        wait_settled();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        for (int round = 0; round < 5; round++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (i % 2 == 0)
                    send_insert({$urandom});
                else
                    send_word(alle_pkg::CMD_READ, any_used_slot(1'b1), 32'h0);
            end
            wait_settled();
        end
    endtask

    task automatic test_random_mix();
        int grow_pct;
        int r;
        for (int blk = 0; blk < 8; blk++)
        begin
            grow_pct     = (blk % 2 == 0) ? 80 : 25;
            src_gaps_on  = (blk != 3);
            sink_gaps_on = (blk != 3 && blk != 6);
            for (int i = 0; i < 100; i++)
            begin
                r = $urandom_range(99, 0);
                if (r < 8)
                    send_word(alle_pkg::cmd_t'($urandom_range(3, 0)),
                              8'($urandom_range(255, 0)), {$urandom});
                else if (r < 23)
                    send_word(alle_pkg::CMD_READ, 8'($urandom_range(255, 0)), {$urandom});
                else if ($urandom_range(99, 0) < grow_pct || free_len == 9'(NSLOT - 1))
                    send_insert({$urandom});
                else
                    send_word(alle_pkg::CMD_DELETE, any_used_slot(1'b0), {$urandom});
            end
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        wait_settled();
    endtask

    initial
    begin
        cmd_if.valid   = 1'b0;
        cmd_if.command = alle_pkg::CMD_READ;
        cmd_if.slot    = '0;
        cmd_if.value   = '0;
        reset_list();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_guards_and_edges();
        test_fill_to_capacity();
        test_drain_to_empty();
        test_output_stall();
        test_sender_pause();
        test_random_mix();

        wait_settled();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("array_linked_list_engine_tb OK");
        else
            $display("array_linked_list_engine_tb NOT OK");
        $finish;
    end

endmodule
